FILE: hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps
package skt_pkg;

  // Table geometry
  localparam int DEPTH    = 1024;
  localparam int KEY_BITS = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = ADDR_W + 1;

  // Port field widths
  localparam int OP_W   = 3;
  localparam int KEY_W  = 64;
  localparam int RANK_W = 10;
  localparam int ST_W   = 3;
  localparam int CMP_W  = (RANK_W > CNT_W) ? RANK_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_SET    = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_CONFLICT = 3'd1,
    ST_FULL     = 3'd2,
    ST_UNSORTED = 3'd3,
    ST_RANGE    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_CHK,
    S_LK_PROBE,
    S_LK_CMP,
    S_GET_CHK,
    S_PUSH
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    rd_last;
    logic    append;
    logic    lk_init;
    logic    lk_rd;
    logic    lk_lo;
    logic    lk_hi;
    logic    flag_wr;
    logic    get_rd;
    logic    clear;
    logic    res_load;
    status_t res_status;
    logic    res_use_mid;
    logic    res_use_flag;
    logic    res_added;
    logic    out_load;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic count_full;
    logic sorted;
    logic rank_ok;
    logic lo_lt_hi;
    logic key_eq;
    logic key_gt;
    logic key_lt;
    logic flag_eq;
  } dp_stat_t;

endpackage

FILE: hw/rtl/skt_ctrl.sv
`timescale 1ns / 1ps
module skt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  skt_pkg::dp_stat_t stat_i,
  output skt_pkg::dp_cmd_t  cmd_o
);
  import skt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register holds a result until the transaction completes
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.op)
          OP_ADD:    state_nxt = stat_i.count_zero ? S_PUSH : S_ADD_CHK;
          OP_LOOKUP: state_nxt = stat_i.sorted ? S_LK_PROBE : S_PUSH;
          OP_GET:    state_nxt = stat_i.rank_ok ? S_GET_CHK : S_PUSH;
          default:   state_nxt = S_PUSH;
        endcase
      end
      S_ADD_CHK:  state_nxt = S_PUSH;
      S_LK_PROBE: state_nxt = stat_i.lo_lt_hi ? S_LK_CMP : S_PUSH;
      S_LK_CMP: begin
        if (stat_i.key_lt || stat_i.key_gt) begin
          state_nxt = S_LK_PROBE;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_GET_CHK: state_nxt = S_PUSH;
      S_PUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        cmd_o.capture = in_valid;
      end
      S_DISPATCH: begin
        case (stat_i.op)
          OP_ADD: begin
            if (stat_i.count_zero) begin
              cmd_o.append    = 1'b1;
              cmd_o.res_load  = 1'b1;
              cmd_o.res_added = 1'b1;
            end else begin
              cmd_o.rd_last = 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (stat_i.sorted) begin
              cmd_o.lk_init = 1'b1;
            end else begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_UNSORTED;
            end
          end
          OP_SET: begin
            cmd_o.res_load = 1'b1;
            if (stat_i.rank_ok) begin
              cmd_o.flag_wr = 1'b1;
            end else begin
              cmd_o.res_status = ST_RANGE;
            end
          end
          OP_GET: begin
            if (stat_i.rank_ok) begin
              cmd_o.get_rd = 1'b1;
            end else begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_RANGE;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear    = 1'b1;
            cmd_o.res_load = 1'b1;
          end
          default: begin
            cmd_o.res_load = 1'b1;
          end
        endcase
      end
      S_ADD_CHK: begin
        cmd_o.res_load = 1'b1;
        if (stat_i.key_eq && !stat_i.flag_eq) begin
          cmd_o.res_status = ST_CONFLICT;
        end else if (stat_i.key_eq && stat_i.sorted) begin
          cmd_o.res_status = ST_OK;
        end else if (stat_i.count_full) begin
          cmd_o.res_status = ST_FULL;
        end else begin
          cmd_o.append    = 1'b1;
          cmd_o.res_added = 1'b1;
        end
      end
      S_LK_PROBE: begin
        if (stat_i.lo_lt_hi) begin
          cmd_o.lk_rd = 1'b1;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOTFOUND;
        end
      end
      S_LK_CMP: begin
        if (stat_i.key_lt) begin
          cmd_o.lk_lo = 1'b1;
        end else if (stat_i.key_gt) begin
          cmd_o.lk_hi = 1'b1;
        end else begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_use_mid = 1'b1;
        end
      end
      S_GET_CHK: begin
        cmd_o.res_load     = 1'b1;
        cmd_o.res_use_flag = 1'b1;
      end
      S_PUSH: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o.res_load = 1'b0;
      end
    endcase
  end

  // Checks
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISPATCH))
    else $error("accepted transaction did not reach dispatch");

  a_result_then_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.res_load |=> (state_r == S_PUSH))
    else $error("result staged without moving to push");

  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_PUSH))
    else $error("output valid raised outside push");

endmodule

FILE: hw/rtl/skt_dpath.sv
`timescale 1ns / 1ps
module skt_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [skt_pkg::OP_W-1:0]     in_opcode,
  input  logic [skt_pkg::KEY_W-1:0]    in_key,
  input  logic                         in_flag_in,
  input  logic [skt_pkg::RANK_W-1:0]   in_rank,
  input  skt_pkg::dp_cmd_t             cmd_i,
  output skt_pkg::dp_stat_t            stat_o,
  output logic [skt_pkg::ST_W-1:0]     out_status,
  output logic [skt_pkg::RANK_W-1:0]   out_rank_out,
  output logic                         out_flag_out,
  output logic                         out_added
);
  import skt_pkg::*;

  // Key and flag stores, one write and one registered read port each
  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic                flag_mem [DEPTH];
  logic [KEY_BITS-1:0] key_q_r;
  logic                flag_q_r;

  // Captured transaction
  op_t                 op_r;
  logic [KEY_BITS-1:0] key_r;
  logic                flag_r;
  logic [RANK_W-1:0]   rank_r;

  // Table state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             sorted_r, sorted_nxt;

  // Search window
  logic [CNT_W-1:0]  lo_r, hi_r;
  logic [CNT_W-1:0]  mid_full;
  logic [ADDR_W-1:0] mid_r;

  // Staged result and output register
  status_t           res_status_r;
  logic [RANK_W-1:0] res_rank_r;
  logic              res_flag_r;
  logic              res_added_r;
  status_t           out_status_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_flag_r;
  logic              out_added_r;

  logic [ADDR_W-1:0] last_addr;
  logic [ADDR_W-1:0] key_rd_addr;
  logic [ADDR_W-1:0] flag_rd_addr;
  logic [ADDR_W-1:0] flag_wr_addr;
  logic [ADDR_W-1:0] app_addr;
  logic [CNT_W-1:0]  last_idx;
  logic              key_rd_en;
  logic              flag_rd_en;
  logic              flag_wr_en;

  // Address selection
  assign last_idx     = count_r - CNT_W'(1);
  assign last_addr    = last_idx[ADDR_W-1:0];
  assign app_addr     = count_r[ADDR_W-1:0];
  assign mid_full     = lo_r + ((hi_r - lo_r) >> 1);
  assign key_rd_en    = cmd_i.rd_last || cmd_i.lk_rd;
  assign key_rd_addr  = cmd_i.rd_last ? last_addr : mid_full[ADDR_W-1:0];
  assign flag_rd_en   = cmd_i.rd_last || cmd_i.get_rd;
  assign flag_rd_addr = cmd_i.rd_last ? last_addr : ADDR_W'(rank_r);
  assign flag_wr_en   = cmd_i.append || cmd_i.flag_wr;
  assign flag_wr_addr = cmd_i.append ? app_addr : ADDR_W'(rank_r);

  // Key memory
  always_ff @(posedge clk) begin
    if (cmd_i.append) key_mem[app_addr] <= key_r;
    if (key_rd_en) key_q_r <= key_mem[key_rd_addr];
  end

  // Flag memory
  always_ff @(posedge clk) begin
    if (flag_wr_en) flag_mem[flag_wr_addr] <= flag_r;
    if (flag_rd_en) flag_q_r <= flag_mem[flag_rd_addr];
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op_r   <= op_t'(in_opcode);
      key_r  <= in_key[KEY_BITS-1:0];
      flag_r <= in_flag_in;
      rank_r <= in_rank;
    end
  end

  // Count and sorted mark
  always_comb begin
    count_nxt  = count_r;
    sorted_nxt = sorted_r;
    if (cmd_i.clear) begin
      count_nxt  = '0;
      sorted_nxt = 1'b1;
    end else if (cmd_i.append) begin
      count_nxt = count_r + CNT_W'(1);
      // new key below the last one breaks the order
      if (!stat_o.count_zero && stat_o.key_gt) sorted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sorted_r <= 1'b1;
    end else begin
      count_r  <= count_nxt;
      sorted_r <= sorted_nxt;
    end
  end

  // Binary search window
  always_ff @(posedge clk) begin
    if (cmd_i.lk_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end else if (cmd_i.lk_lo) begin
      lo_r <= CNT_W'(mid_r) + CNT_W'(1);
    end else if (cmd_i.lk_hi) begin
      hi_r <= CNT_W'(mid_r);
    end
    if (cmd_i.lk_rd) mid_r <= mid_full[ADDR_W-1:0];
  end

  // Result staging
  always_ff @(posedge clk) begin
    if (cmd_i.res_load) begin
      res_status_r <= cmd_i.res_status;
      res_rank_r   <= cmd_i.res_use_mid ? RANK_W'(mid_r) : '0;
      res_flag_r   <= cmd_i.res_use_flag ? flag_q_r : 1'b0;
      res_added_r  <= cmd_i.res_added;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_status_r <= res_status_r;
      out_rank_r   <= res_rank_r;
      out_flag_r   <= res_flag_r;
      out_added_r  <= res_added_r;
    end
  end

  assign out_status   = out_status_r;
  assign out_rank_out = out_rank_r;
  assign out_flag_out = out_flag_r;
  assign out_added    = out_added_r;

  // Status to controller
  always_comb begin
    stat_o.op         = op_r;
    stat_o.count_zero = (count_r == '0);
    stat_o.count_full = (count_r == CNT_W'(DEPTH));
    stat_o.sorted     = sorted_r;
    stat_o.rank_ok    = (CMP_W'(rank_r) < CMP_W'(count_r));
    stat_o.lo_lt_hi   = (lo_r < hi_r);
    stat_o.key_eq     = (key_q_r == key_r);
    stat_o.key_gt     = (key_q_r > key_r);
    stat_o.key_lt     = (key_q_r < key_r);
    stat_o.flag_eq    = (flag_q_r == flag_r);
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.append |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not advance the entry count by one");

endmodule

FILE: hw/rtl/sorted_key_table_binary_search_unit.sv
`timescale 1ns / 1ps
// Sequence, accept to result valid: set, clear, unknown opcodes, out-of-range get, lookup
// while unsorted and add to an empty table go from dispatch to push; other add and get pass
// a check state on the registered read first; a lookup runs P probes (at most 11 over 1024
// entries), each a probe state with a registered key read, then a compare state.
// A new transaction is taken after the result is loaded to the output; a held output stalls it.
// Reset (synchronous, rst_n low) empties the table and sets the sorted mark; memories keep data.
module sorted_key_table_binary_search_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [skt_pkg::OP_W-1:0]   in_opcode,
  input  logic [skt_pkg::KEY_W-1:0]  in_key,
  input  logic                       in_flag_in,
  input  logic [skt_pkg::RANK_W-1:0] in_rank,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [skt_pkg::ST_W-1:0]   out_status,
  output logic [skt_pkg::RANK_W-1:0] out_rank_out,
  output logic                       out_flag_out,
  output logic                       out_added
);
  import skt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Table storage and search datapath
  skt_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_opcode    (in_opcode),
    .in_key       (in_key),
    .in_flag_in   (in_flag_in),
    .in_rank      (in_rank),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_status   (out_status),
    .out_rank_out (out_rank_out),
    .out_flag_out (out_flag_out),
    .out_added    (out_added)
  );

endmodule
